[rtl/cts_pkg.sv]
// Shared types, field widths and codes for the sparse transpose scatter engine.
`default_nettype none
package cts_pkg;

    localparam int KIND_W   = 2;
    localparam int ROW_W    = 11;
    localparam int COL_W    = 10;
    localparam int CUR_W    = 17;
    localparam int ADDR_W   = 16;
    localparam int VCOUNT_W = 11;

    localparam int S_TDATA_W = 40;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 48;
    localparam int M_TUSER_W = 2;

    localparam int S_ROW_LSB   = 0;
    localparam int S_COL_LSB   = S_ROW_LSB + ROW_W;
    localparam int S_START_LSB = S_COL_LSB + COL_W;

    localparam int M_ADDR_LSB = 0;
    localparam int M_COL_LSB  = M_ADDR_LSB + ADDR_W;
    localparam int M_RP_LSB   = M_COL_LSB + COL_W;
    localparam int M_WV_BIT   = 0;
    localparam int M_ERR_BIT  = 1;

    localparam int DEF_MAX_VERTICES = 1024;
    localparam int DEF_MAX_EDGES    = 65536;
    localparam int ADDR_SPACE       = 65536;

    localparam logic [VCOUNT_W-1:0] VCOUNT_RESET = 11'd1024;

    typedef enum logic [KIND_W-1:0] {
        KIND_LOAD    = 2'd0,
        KIND_NONZERO = 2'd1,
        KIND_READ    = 2'd2
    } kind_t;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_EXEC = 1'b1
    } state_t;

    typedef struct packed {
        logic capture;
        logic execute;
    } cmd_t;

    typedef struct packed {
        logic out_busy;
    } status_t;

endpackage
`default_nettype wire

[rtl/cts_ctrl.sv]
// Controller state machine that sequences capture and execution of each beat.
`default_nettype none
module cts_ctrl (
    input  wire               aclk,
    input  wire               aresetn,
    input  wire               s_tvalid,
    output logic              s_tready,
    input  cts_pkg::status_t  status,
    output cts_pkg::cmd_t     cmd
);

    cts_pkg::state_t state_reg;
    cts_pkg::state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= cts_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next  = state_reg;
        s_tready    = 1'b0;
        cmd.capture = 1'b0;
        cmd.execute = 1'b0;
        case (state_reg)
            cts_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.capture = 1'b1;
                    state_next  = cts_pkg::ST_EXEC;
                end
            end
            cts_pkg::ST_EXEC: begin
                if (!status.out_busy) begin
                    cmd.execute = 1'b1;
                    state_next  = cts_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = cts_pkg::ST_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

[rtl/cts_datapath.sv]
// Datapath with the row cursor memory, item registers and the result register.
`default_nettype none
module cts_datapath #(
    parameter int MAX_VERTICES = cts_pkg::DEF_MAX_VERTICES,
    parameter int MAX_EDGES    = cts_pkg::DEF_MAX_EDGES
) (
    input  wire                               aclk,
    input  wire                               aresetn,
    input  wire                               cfg_wen,
    input  wire  [cts_pkg::VCOUNT_W-1:0]      cfg_wdata,
    input  wire  [cts_pkg::S_TDATA_W-1:0]     s_tdata,
    input  wire  [cts_pkg::S_TUSER_W-1:0]     s_tuser,
    output logic                              m_tvalid,
    input  wire                               m_tready,
    output logic [cts_pkg::M_TDATA_W-1:0]     m_tdata,
    output logic [cts_pkg::M_TUSER_W-1:0]     m_tuser,
    input  cts_pkg::cmd_t                     cmd,
    output cts_pkg::status_t                  status
);

    localparam int IDX_W      = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
    localparam int EDGE_LIMIT = (MAX_EDGES > cts_pkg::ADDR_SPACE) ?
                                cts_pkg::ADDR_SPACE : MAX_EDGES;
    localparam int ROW_W = cts_pkg::ROW_W;
    localparam int COL_W = cts_pkg::COL_W;
    localparam int CUR_W = cts_pkg::CUR_W;

    logic [CUR_W-1:0] cursor_mem [MAX_VERTICES];

    logic [cts_pkg::VCOUNT_W-1:0] vcount_reg;
    logic [cts_pkg::KIND_W-1:0]   kind_reg;
    logic [ROW_W-1:0]             row_reg;
    logic [COL_W-1:0]             col_reg;
    logic [CUR_W-1:0]             start_reg;
    logic [CUR_W-1:0]             cursor_reg;

    logic                         out_valid_reg;
    logic                         out_valid_next;
    logic [cts_pkg::M_TDATA_W-1:0] out_data_reg;
    logic [cts_pkg::M_TUSER_W-1:0] out_user_reg;

    logic [ROW_W-1:0]         in_row;
    logic [ROW_W-1:0]         rd_row;
    logic [IDX_W+ROW_W-1:0]   rd_ext;
    logic [IDX_W-1:0]         rd_idx;
    logic [IDX_W+ROW_W-1:0]   wr_ext;
    logic [IDX_W-1:0]         wr_idx;

    logic                     row_lt;
    logic                     row_le;
    logic                     at_limit;
    logic                     wr_en;
    logic [CUR_W-1:0]         wr_data;
    logic                     res_wv;
    logic [cts_pkg::ADDR_W-1:0] res_addr;
    logic [COL_W-1:0]         res_col;
    logic [CUR_W-1:0]         res_rp;
    logic                     res_err;

    assign in_row = s_tdata[cts_pkg::S_ROW_LSB +: ROW_W];
    assign rd_row = (s_tuser == cts_pkg::KIND_READ) ? (in_row - ROW_W'(1)) : in_row;
    assign rd_ext = {{IDX_W{1'b0}}, rd_row};
    assign rd_idx = rd_ext[IDX_W-1:0];
    assign wr_ext = {{IDX_W{1'b0}}, row_reg};
    assign wr_idx = wr_ext[IDX_W-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vcount_reg <= cts_pkg::VCOUNT_RESET;
        end else if (cfg_wen) begin
            vcount_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            kind_reg   <= s_tuser;
            row_reg    <= in_row;
            col_reg    <= s_tdata[cts_pkg::S_COL_LSB +: COL_W];
            start_reg  <= s_tdata[cts_pkg::S_START_LSB +: CUR_W];
            cursor_reg <= cursor_mem[rd_idx];
        end
        if (wr_en) begin
            cursor_mem[wr_idx] <= wr_data;
        end
    end

    assign row_lt   = (row_reg < vcount_reg) && (32'(row_reg) < 32'(MAX_VERTICES));
    assign row_le   = (row_reg <= vcount_reg) && (32'(row_reg) <= 32'(MAX_VERTICES));
    assign at_limit = 32'(cursor_reg) >= 32'(EDGE_LIMIT);

    always_comb begin
        wr_en    = 1'b0;
        wr_data  = start_reg;
        res_wv   = 1'b0;
        res_addr = '0;
        res_col  = '0;
        res_rp   = '0;
        res_err  = 1'b0;
        case (kind_reg)
            cts_pkg::KIND_LOAD: begin
                if (row_lt) begin
                    wr_en = cmd.execute;
                end else begin
                    res_err = 1'b1;
                end
            end
            cts_pkg::KIND_NONZERO: begin
                if (!row_lt || at_limit) begin
                    res_err = 1'b1;
                end else begin
                    wr_en    = cmd.execute;
                    wr_data  = cursor_reg + CUR_W'(1);
                    res_wv   = 1'b1;
                    res_addr = cursor_reg[cts_pkg::ADDR_W-1:0];
                    res_col  = col_reg;
                end
            end
            cts_pkg::KIND_READ: begin
                if (row_reg == '0) begin
                    res_rp = '0;
                end else if (row_le) begin
                    res_rp = cursor_reg;
                end else begin
                    res_err = 1'b1;
                end
            end
            default: begin
                res_err = 1'b0;
            end
        endcase
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (cmd.execute) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.execute) begin
            out_data_reg <= {(cts_pkg::M_TDATA_W - cts_pkg::M_RP_LSB - CUR_W)'(0),
                             res_rp, res_col, res_addr};
            out_user_reg <= {res_err, res_wv};
        end
    end

    assign status.out_busy = out_valid_reg && !m_tready;
    assign m_tvalid        = out_valid_reg;
    assign m_tdata         = out_data_reg;
    assign m_tuser         = out_user_reg;

endmodule
`default_nettype wire

[rtl/csc_to_csr_scatter.sv]
// Top level of the sparse transpose scatter engine.
//
// Channel   Direction  Handshake          Payload
// s_        in         s_tvalid/s_tready  kind in tuser; row, column, start in tdata
// m_        out        m_tvalid/m_tready  write_valid, error in tuser; address,
//                                         column, row pointer in tdata
// cfg_      in         cfg_wen            vertex_count
//
// Each beat is first captured, with the registered read of the row cursor
// memory, then executed, with the cursor update and result register load.
// A new beat is accepted while an earlier result waits in the result register;
// execution holds only while that register is full and m_tready is low.
// Reset clears the controller and the result valid; the cursor memory is not
// cleared, and a cursor must be loaded before it is used.
`default_nettype none
module csc_to_csr_scatter #(
    parameter int MAX_VERTICES = cts_pkg::DEF_MAX_VERTICES,
    parameter int MAX_EDGES    = cts_pkg::DEF_MAX_EDGES
) (
    input  wire                           aclk,
    input  wire                           aresetn,
    input  wire                           cfg_wen,
    input  wire  [cts_pkg::VCOUNT_W-1:0]  cfg_wdata,
    input  wire                           s_tvalid,
    output logic                          s_tready,
    // row_index [10:0], column [20:11], start_offset [37:21], zero pad above.
    input  wire  [cts_pkg::S_TDATA_W-1:0] s_tdata,
    // kind [1:0].
    input  wire  [cts_pkg::S_TUSER_W-1:0] s_tuser,
    output logic                          m_tvalid,
    input  wire                           m_tready,
    // write_address [15:0], write_column [25:16], row_pointer [42:26], zero pad above.
    output logic [cts_pkg::M_TDATA_W-1:0] m_tdata,
    // write_valid [0], error [1].
    output logic [cts_pkg::M_TUSER_W-1:0] m_tuser
);

    cts_pkg::cmd_t    cmd;
    cts_pkg::status_t status;

    cts_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    cts_datapath #(
        .MAX_VERTICES (MAX_VERTICES),
        .MAX_EDGES    (MAX_EDGES)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wen   (cfg_wen),
        .cfg_wdata (cfg_wdata),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cmd       (cmd),
        .status    (status)
    );

    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("Input accepted while a beat is still in execution.");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tuser[cts_pkg::M_WV_BIT] && m_tuser[cts_pkg::M_ERR_BIT]))
        else $error("Result flags both a write and an error.");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser[cts_pkg::M_WV_BIT]) |->
            (m_tdata[cts_pkg::M_RP_LSB-1:0] == '0))
        else $error("Write fields are nonzero without a write.");

    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> !$past(s_tready))
        else $error("Result appeared without an executing beat.");

endmodule
`default_nettype wire
